### design/vrp_pkg.sv
// vrp_pkg: shared types and constants of the monitor-link record parser
// used by vrp_csr, vrp_parse and ventilator_record_parser; no dependencies

package vrp_pkg;

   // store size for record channels, 1 to 32
   localparam int MAX_CHANNELS = 32;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 8;
   localparam int REQ_DATA_W  = 8;
   localparam int RSP_DATA_W  = 40;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_CURVE_COUNT  = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_END_FLAG     = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_VALUE_FLAG   = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_PHASE_FLAG   = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_STANDBY      = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_BUFFER_FULL  = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] CSR_ESCAPE_STOP  = 3'd6;

   // result kinds
   localparam logic [2:0] KIND_BREATH_VALUE  = 3'd0;
   localparam logic [2:0] KIND_SETTING_VALUE = 3'd1;
   localparam logic [2:0] KIND_CURVE_VALUE   = 3'd2;
   localparam logic [2:0] KIND_PHASE         = 3'd3;
   localparam logic [2:0] KIND_BREATH_END    = 3'd4;
   localparam logic [2:0] KIND_SETTINGS_END  = 3'd5;
   localparam logic [2:0] KIND_ERROR         = 3'd6;

   // error classes
   localparam logic [1:0] ERR_STANDBY     = 2'd0;
   localparam logic [1:0] ERR_BUFFER_FULL = 2'd1;
   localparam logic [1:0] ERR_ESCAPE_STOP = 2'd2;
   localparam logic [1:0] ERR_OTHER       = 2'd3;

   // fixed header bytes
   localparam logic [7:0] HDR_SETTINGS = 8'h53;
   localparam logic [7:0] HDR_BREATH   = 8'h42;
   localparam logic [7:0] HDR_TREND    = 8'h54;
   localparam logic [7:0] HDR_ALARM    = 8'h41;
   localparam logic [7:0] HDR_ERROR    = 8'hE0;
   localparam logic [7:0] HDR_VALUE    = 8'h80;
   localparam logic [7:0] HDR_PHASE    = 8'h81;

   localparam logic [15:0] NO_DATA_MARK = 16'd32511;

   typedef struct packed {
      logic [2:0] curve_count;
      logic [7:0] end_flag_code;
      logic [7:0] value_flag_code;
      logic [7:0] phase_flag_code;
      logic [7:0] standby_code;
      logic [7:0] buffer_full_code;
      logic [7:0] escape_stop_code;
   } cfg_type;

   // last member sits in the lowest bits
   typedef struct packed {
      logic        link_open;
      logic [1:0]  error_class;
      logic        overflow;
      logic [5:0]  channel_total;
      logic        no_valid_data;
      logic [15:0] value;
      logic [4:0]  channel;
      logic [2:0]  kind;
   } rsp_type;

endpackage

### design/vrp_csr.sv
// vrp_csr: configuration registers of the record parser
// depends on vrp_pkg

module vrp_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             wr_en,
   input  logic [vrp_pkg::CSR_INDEX_W-1:0]  wr_index,
   input  logic [vrp_pkg::CSR_DATA_W-1:0]   wr_data,
   output vrp_pkg::cfg_type                 cfg
);

   vrp_pkg::cfg_type cfg_ff, cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (wr_index)
            vrp_pkg::CSR_CURVE_COUNT: cfg_in.curve_count      = wr_data[2:0];
            vrp_pkg::CSR_END_FLAG:    cfg_in.end_flag_code    = wr_data;
            vrp_pkg::CSR_VALUE_FLAG:  cfg_in.value_flag_code  = wr_data;
            vrp_pkg::CSR_PHASE_FLAG:  cfg_in.phase_flag_code  = wr_data;
            vrp_pkg::CSR_STANDBY:     cfg_in.standby_code     = wr_data;
            vrp_pkg::CSR_BUFFER_FULL: cfg_in.buffer_full_code = wr_data;
            vrp_pkg::CSR_ESCAPE_STOP: cfg_in.escape_stop_code = wr_data;
            default:                  cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.curve_count      <= 3'd1;
         cfg_ff.end_flag_code    <= 8'h7F;
         cfg_ff.value_flag_code  <= 8'h80;
         cfg_ff.phase_flag_code  <= 8'h81;
         cfg_ff.standby_code     <= 8'h00;
         cfg_ff.buffer_full_code <= 8'h01;
         cfg_ff.escape_stop_code <= 8'h02;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

### design/vrp_parse.sv
// vrp_parse: record stream state and per-byte result logic
// depends on vrp_pkg; result is combinational, registered by the caller

module vrp_parse (
   input  logic              clock,
   input  logic              reset,
   input  logic              accept,
   input  logic [7:0]        rx_byte,
   input  vrp_pkg::cfg_type  cfg,
   output logic              has_result,
   output vrp_pkg::rsp_type  result
);

   localparam logic [3:0] M_AWAIT    = 4'd0;
   localparam logic [3:0] M_ENDSKIP  = 4'd1;
   localparam logic [3:0] M_BREATH   = 4'd2;
   localparam logic [3:0] M_SETTINGS = 4'd3;
   localparam logic [3:0] M_VALUE    = 4'd4;
   localparam logic [3:0] M_PHASE    = 4'd5;
   localparam logic [3:0] M_TREND    = 4'd6;
   localparam logic [3:0] M_ALARM    = 4'd7;
   localparam logic [3:0] M_ERROR    = 4'd8;
   localparam logic [3:0] M_RUN      = 4'd9;

   localparam logic [6:0] MAX_CH = 7'(vrp_pkg::MAX_CHANNELS);

   logic [3:0] mode_ff, mode_in;
   logic [1:0] left_ff, left_in;
   logic [5:0] index_ff, index_in;
   logic [7:0] high_ff, high_in;
   logic [1:0] slot_ff, slot_in;
   logic       link_ff, link_in;
   logic       drop_ff, drop_in;

   logic [6:0] total;
   logic [2:0] slot_next;
   logic [2:0] rec_value_kind, rec_end_kind;

   always_comb begin
      // last index plus one, limited to the store size and to 63
      total = 7'(index_ff) + 7'd1;
      if (total > MAX_CH) total = MAX_CH;
      if (total > 7'd63)  total = 7'd63;
      slot_next = 3'(slot_ff) + 3'd1;
      rec_value_kind = (mode_ff == M_SETTINGS) ? vrp_pkg::KIND_SETTING_VALUE
                                               : vrp_pkg::KIND_BREATH_VALUE;
      rec_end_kind   = (mode_ff == M_SETTINGS) ? vrp_pkg::KIND_SETTINGS_END
                                               : vrp_pkg::KIND_BREATH_END;
   end

   always_comb begin
      mode_in  = mode_ff;
      left_in  = left_ff;
      index_in = index_ff;
      high_in  = high_ff;
      slot_in  = slot_ff;
      link_in  = link_ff;
      drop_in  = drop_ff;
      has_result = 1'b0;
      result = '0;

      case (mode_ff)
         M_AWAIT: begin
            case (rx_byte)
               vrp_pkg::HDR_SETTINGS, vrp_pkg::HDR_BREATH: begin
                  mode_in  = (rx_byte == vrp_pkg::HDR_SETTINGS) ? M_SETTINGS : M_BREATH;
                  index_in = '0;
                  left_in  = 2'd2;
                  drop_in  = 1'b0;
               end
               vrp_pkg::HDR_TREND: mode_in = M_TREND;
               vrp_pkg::HDR_ALARM: mode_in = M_ALARM;
               vrp_pkg::HDR_ERROR: begin
                  mode_in = M_ERROR;
                  left_in = 2'd1;
               end
               vrp_pkg::HDR_VALUE: begin
                  mode_in = M_VALUE;
                  left_in = 2'd2;
               end
               vrp_pkg::HDR_PHASE: begin
                  mode_in = M_PHASE;
                  left_in = 2'd1;
               end
               default: mode_in = M_AWAIT;
            endcase
         end
         M_ENDSKIP: mode_in = M_AWAIT;
         M_BREATH, M_SETTINGS: begin
            if (left_ff == 2'd2) begin
               high_in = rx_byte;
               left_in = 2'd1;
            end else if (left_ff == 2'd0 && rx_byte == cfg.end_flag_code) begin
               has_result = 1'b1;
               result.kind = rec_end_kind;
               result.channel_total = total[5:0];
               result.overflow = drop_ff;
               mode_in = M_ENDSKIP;
            end else if (left_ff == 2'd0) begin
               if (index_ff != 6'd63) index_in = index_ff + 6'd1;
               high_in = rx_byte;
               left_in = 2'd1;
            end else begin
               left_in = 2'd0;
               if (7'(index_ff) >= MAX_CH) begin
                  drop_in = 1'b1;
               end else begin
                  has_result = 1'b1;
                  result.kind = rec_value_kind;
                  result.channel = index_ff[4:0];
                  result.value = {high_ff, rx_byte};
               end
            end
         end
         M_VALUE: begin
            if (left_ff == 2'd2) begin
               high_in = rx_byte;
               left_in = 2'd1;
            end else if (left_ff == 2'd1) begin
               has_result = 1'b1;
               result.kind = vrp_pkg::KIND_CURVE_VALUE;
               result.channel = 5'(slot_ff);
               result.value = {high_ff, rx_byte};
               slot_in = (cfg.curve_count > slot_next && slot_ff != 2'd3)
                         ? slot_next[1:0] : 2'd0;
               left_in = 2'd0;
               mode_in = M_RUN;
            end
         end
         M_PHASE: begin
            has_result = 1'b1;
            result.kind = vrp_pkg::KIND_PHASE;
            result.value = 16'(rx_byte);
            left_in = 2'd0;
            mode_in = M_RUN;
         end
         M_TREND, M_ALARM: begin
            if (rx_byte == cfg.end_flag_code) mode_in = M_ENDSKIP;
         end
         M_ERROR: begin
            if (rx_byte == cfg.end_flag_code) begin
               mode_in = M_ENDSKIP;
            end else begin
               has_result = 1'b1;
               result.kind = vrp_pkg::KIND_ERROR;
               result.value = 16'(rx_byte);
               if (rx_byte == cfg.standby_code) begin
                  result.error_class = vrp_pkg::ERR_STANDBY;
                  link_in = 1'b0;
               end else if (rx_byte == cfg.buffer_full_code) begin
                  result.error_class = vrp_pkg::ERR_BUFFER_FULL;
               end else if (rx_byte == cfg.escape_stop_code) begin
                  result.error_class = vrp_pkg::ERR_ESCAPE_STOP;
               end else begin
                  result.error_class = vrp_pkg::ERR_OTHER;
               end
            end
         end
         M_RUN: begin
            if (rx_byte == cfg.value_flag_code) begin
               mode_in = M_VALUE;
               left_in = 2'd2;
            end else if (rx_byte == cfg.phase_flag_code) begin
               mode_in = M_PHASE;
               left_in = 2'd1;
            end else if (rx_byte == cfg.end_flag_code) begin
               mode_in = M_ENDSKIP;
            end
         end
         default: mode_in = M_AWAIT;
      endcase

      result.no_valid_data = (result.kind == vrp_pkg::KIND_BREATH_VALUE ||
                              result.kind == vrp_pkg::KIND_SETTING_VALUE ||
                              result.kind == vrp_pkg::KIND_CURVE_VALUE) &&
                             (result.value == vrp_pkg::NO_DATA_MARK);
      result.link_open = link_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= M_AWAIT;
         left_ff  <= 2'd0;
         index_ff <= 6'd0;
         high_ff  <= 8'd0;
         slot_ff  <= 2'd0;
         link_ff  <= 1'b1;
         drop_ff  <= 1'b0;
      end else if (accept) begin
         mode_ff  <= mode_in;
         left_ff  <= left_in;
         index_ff <= index_in;
         high_ff  <= high_in;
         slot_ff  <= slot_in;
         link_ff  <= link_in;
         drop_ff  <= drop_in;
      end
   end

`ifndef SYNTHESIS
   // two-byte value count never holds its unused code
   a_left_range: assert property (@(posedge clock) disable iff (reset)
      left_ff != 2'd3)
      else $error("bytes-left counter out of range");

   // only reset reopens the link
   a_link_no_reopen: assert property (@(posedge clock) disable iff (reset)
      !link_ff |=> !link_ff)
      else $error("link flag set without reset");

   // record end always reports at least one channel
   a_end_total: assert property (@(posedge clock) disable iff (reset)
      (has_result && (result.kind == vrp_pkg::KIND_BREATH_END ||
                      result.kind == vrp_pkg::KIND_SETTINGS_END))
      |-> result.channel_total != 6'd0)
      else $error("end result with zero channel total");
`endif

endmodule

### design/ventilator_record_parser.sv
// ventilator_record_parser: top level of the monitor-link record parser
// depends on vrp_pkg, vrp_csr and vrp_parse
//
// usage:
//  - req_* carries one received link byte per item (req_tdata[7:0])
//  - rsp_* carries at most one result item per accepted byte
//  - csr_* writes one configuration register per handshake, csr_ready is
//    always high; write only while the parser is idle
//  - a byte's result is written at the edge that accepts the byte, into the
//    output register, or into the skid register while the output is stalled
//  - throughput: one byte per cycle while req_tready is high, set by the
//    combinational parse step between the state registers and output register
//  - a two-entry output stage (output register plus skid register) lets a
//    byte be accepted while a finished result waits; req_tready drops
//    only when both entries hold results
//  - reset: parser awaits a record header, link flag open, registers at
//    their defaults, output stage empty
//  - while the receiver stalls, rsp_tdata holds stable until it is taken

module ventilator_record_parser (
   input  logic                             clock,
   input  logic                             reset,
   // input bytes
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [vrp_pkg::REQ_DATA_W-1:0]   req_tdata,   // [7:0] rx_byte
   // results
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // [2:0] kind, [7:3] channel, [23:8] value, [24] no_valid_data,
   // [30:25] channel_total, [31] overflow, [33:32] error_class,
   // [34] link_open, [39:35] zero
   output logic [vrp_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   // configuration writes
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [vrp_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [vrp_pkg::CSR_DATA_W-1:0]   csr_data
);

   vrp_pkg::cfg_type cfg;
   vrp_pkg::rsp_type result;
   logic             has_result;
   logic             accept;
   logic             push;
   logic             pop;

   // output stage: main register drives the port, skid catches overflow
   vrp_pkg::rsp_type main_ff, main_in;
   vrp_pkg::rsp_type skid_ff, skid_in;
   logic             main_valid_ff, main_valid_in;
   logic             skid_valid_ff, skid_valid_in;

   assign csr_ready = 1'b1;

   vrp_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (csr_valid & csr_ready),
      .wr_index (csr_index),
      .wr_data  (csr_data),
      .cfg      (cfg)
   );

   // accepting is safe whenever the skid entry is free
   assign req_tready = !skid_valid_ff;
   assign accept     = req_tvalid & req_tready;

   vrp_parse u_parse (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .rx_byte    (req_tdata),
      .cfg        (cfg),
      .has_result (has_result),
      .result     (result)
   );

   assign push = accept & has_result;
   assign pop  = main_valid_ff & rsp_tready;

   always_comb begin
      main_in       = main_ff;
      skid_in       = skid_ff;
      main_valid_in = main_valid_ff;
      skid_valid_in = skid_valid_ff;
      if (skid_valid_ff) begin
         // no push possible here, ready is low
         if (pop) begin
            main_in       = skid_ff;
            skid_valid_in = 1'b0;
         end
      end else if (push) begin
         if (!main_valid_ff || pop) begin
            main_in       = result;
            main_valid_in = 1'b1;
         end else begin
            skid_in       = result;
            skid_valid_in = 1'b1;
         end
      end else if (pop) begin
         main_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   // payload registers, no reset needed
   always_ff @(posedge clock) begin
      main_ff <= main_in;
      skid_ff <= skid_in;
   end

   assign rsp_tvalid = main_valid_ff;
   assign rsp_tdata  = {5'd0, main_ff};

`ifndef SYNTHESIS
   // skid entry is only ever behind a full main entry
   a_skid_behind_main: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> main_valid_ff)
      else $error("skid entry valid with main entry empty");

   // skid fills only when the main entry was stalled
   a_skid_fill: assert property (@(posedge clock) disable iff (reset)
      !skid_valid_ff && skid_valid_in |-> main_valid_ff && !rsp_tready)
      else $error("skid entry filled without a stall");

   // draining the skid keeps a result on the port
   a_skid_drain: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff && rsp_tready |=> main_valid_ff && !skid_valid_ff)
      else $error("skid entry lost on drain");
`endif

endmodule

### verif/testbench.sv
// testbench for ventilator_record_parser: drives link bytes and register writes,
// predicts every result with an in-house parser model and checks each one
// depends on vrp_pkg and the ventilator_record_parser RTL

module testbench;
   import vrp_pkg::*;

   // longest stretch without any accepted item before the run is called hung
   localparam int WATCHDOG_LIMIT = 2000;
   // cycles allowed for an item with no result to clear the parse stage
   localparam int HOLD_CYCLES = 4;
   localparam int PHASE_COUNT = 9;
   localparam int ITEMS_PER_PHASE = 110;
   // index outside the register map, writes must be ignored
   localparam logic [CSR_INDEX_W-1:0] CSR_UNMAPPED = 3'd7;

   // expected-result tracker: its own copy of the parser state and registers
   class parser_scoreboard;
      typedef enum logic [3:0] {
         AWAIT_HEADER, SKIP_AFTER_END, IN_BREATH, IN_SETTINGS, IN_CURVE_VALUE,
         IN_PHASE, IN_TREND, IN_ALARM, IN_ERROR, IN_RUN
      } parse_mode_e;

      cfg_type     cfg;
      parse_mode_e mode;
      logic [1:0]  bytes_left;
      logic [5:0]  chan_index;
      logic [7:0]  high_byte;
      logic [1:0]  curve_slot;
      logic [7:0]  breath_phase;
      logic        link_flag;
      logic        dropped_flag;
      rsp_type     awaited_results[$];
      int          mismatches;

      function new();
         // register defaults after reset
         cfg = '{3'd1, 8'h7F, 8'h80, 8'h81, 8'h00, 8'h01, 8'h02};
         mode = AWAIT_HEADER;
         bytes_left = '0;
         chan_index = '0;
         high_byte = '0;
         curve_slot = '0;
         breath_phase = '0;
         link_flag = 1'b1;
         dropped_flag = 1'b0;
         mismatches = 0;
      endfunction

      function void write_reg(logic [CSR_INDEX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
         case (idx)
            CSR_CURVE_COUNT: cfg.curve_count = data[2:0];
            CSR_END_FLAG:    cfg.end_flag_code = data;
            CSR_VALUE_FLAG:  cfg.value_flag_code = data;
            CSR_PHASE_FLAG:  cfg.phase_flag_code = data;
            CSR_STANDBY:     cfg.standby_code = data;
            CSR_BUFFER_FULL: cfg.buffer_full_code = data;
            CSR_ESCAPE_STOP: cfg.escape_stop_code = data;
            default: ;
         endcase
      endfunction

      function void queue_result(logic [2:0] kind, logic [4:0] chan, logic [15:0] val,
                                 logic [5:0] total, logic ovf, logic [1:0] cls);
         rsp_type r;
         r.kind = kind;
         r.channel = chan;
         r.value = val;
         r.no_valid_data = (kind <= KIND_CURVE_VALUE) && (val == NO_DATA_MARK);
         r.channel_total = total;
         r.overflow = ovf;
         r.error_class = cls;
         r.link_open = link_flag;
         awaited_results.push_back(r);
      endfunction

      // one byte of a breath or settings record
      function void record_byte(logic [7:0] b, logic [2:0] value_kind, logic [2:0] end_kind);
         int total;
         if (bytes_left == 2'd2) begin
            high_byte = b;
            bytes_left = 2'd1;
         end else if (bytes_left == 2'd0 && b == cfg.end_flag_code) begin
            total = int'(chan_index) + 1;
            if (total > MAX_CHANNELS) total = MAX_CHANNELS;
            if (total > 63) total = 63;
            queue_result(end_kind, '0, '0, total[5:0], dropped_flag, '0);
            mode = SKIP_AFTER_END;
         end else if (bytes_left == 2'd0) begin
            // index saturates at the top of its 6-bit range
            if (chan_index < 6'd63) chan_index++;
            high_byte = b;
            bytes_left = 2'd1;
         end else begin
            bytes_left = 2'd0;
            if (int'(chan_index) >= MAX_CHANNELS) dropped_flag = 1'b1;
            else queue_result(value_kind, chan_index[4:0], {high_byte, b}, '0, 1'b0, '0);
         end
      endfunction

      // advance the parser by one accepted link byte
      function void note_rx_byte(logic [7:0] b);
         logic [1:0] cls;
         case (mode)
            AWAIT_HEADER: begin
               if (b == HDR_SETTINGS || b == HDR_BREATH) begin
                  mode = (b == HDR_SETTINGS) ? IN_SETTINGS : IN_BREATH;
                  chan_index = '0;
                  bytes_left = 2'd2;
                  dropped_flag = 1'b0;
               end else if (b == HDR_TREND) begin
                  mode = IN_TREND;
               end else if (b == HDR_ALARM) begin
                  mode = IN_ALARM;
               end else if (b == HDR_ERROR) begin
                  mode = IN_ERROR;
                  bytes_left = 2'd1;
               end else if (b == HDR_VALUE) begin
                  mode = IN_CURVE_VALUE;
                  bytes_left = 2'd2;
               end else if (b == HDR_PHASE) begin
                  mode = IN_PHASE;
                  bytes_left = 2'd1;
               end
            end
            SKIP_AFTER_END: mode = AWAIT_HEADER;
            IN_BREATH:      record_byte(b, KIND_BREATH_VALUE, KIND_BREATH_END);
            IN_SETTINGS:    record_byte(b, KIND_SETTING_VALUE, KIND_SETTINGS_END);
            IN_CURVE_VALUE: begin
               if (bytes_left == 2'd2) begin
                  high_byte = b;
                  bytes_left = 2'd1;
               end else if (bytes_left == 2'd1) begin
                  queue_result(KIND_CURVE_VALUE, {3'b000, curve_slot}, {high_byte, b},
                               '0, 1'b0, '0);
                  // step to the next slot while curve_count allows, else wrap
                  if (int'(cfg.curve_count) > int'(curve_slot) + 1 && curve_slot != 2'd3)
                     curve_slot = curve_slot + 2'd1;
                  else
                     curve_slot = 2'd0;
                  bytes_left = 2'd0;
                  mode = IN_RUN;
               end
            end
            IN_PHASE: begin
               breath_phase = b;
               bytes_left = 2'd0;
               mode = IN_RUN;
               queue_result(KIND_PHASE, '0, {8'h00, b}, '0, 1'b0, '0);
            end
            IN_TREND, IN_ALARM: begin
               if (b == cfg.end_flag_code) mode = SKIP_AFTER_END;
            end
            IN_ERROR: begin
               if (b == cfg.end_flag_code) begin
                  mode = SKIP_AFTER_END;
               end else begin
                  if (b == cfg.standby_code) begin
                     cls = ERR_STANDBY;
                     link_flag = 1'b0;
                  end else if (b == cfg.buffer_full_code) begin
                     cls = ERR_BUFFER_FULL;
                  end else if (b == cfg.escape_stop_code) begin
                     cls = ERR_ESCAPE_STOP;
                  end else begin
                     cls = ERR_OTHER;
                  end
                  queue_result(KIND_ERROR, '0, {8'h00, b}, '0, 1'b0, cls);
               end
            end
            IN_RUN: begin
               // value flag wins over phase flag, phase flag over end flag
               if (b == cfg.value_flag_code) begin
                  mode = IN_CURVE_VALUE;
                  bytes_left = 2'd2;
               end else if (b == cfg.phase_flag_code) begin
                  mode = IN_PHASE;
                  bytes_left = 2'd1;
               end else if (b == cfg.end_flag_code) begin
                  mode = SKIP_AFTER_END;
               end
            end
            default: mode = AWAIT_HEADER;
         endcase
      endfunction

      function string show(rsp_type r);
         return $sformatf("kind %0d ch %0d value %h nvd %b total %0d ovf %b class %0d link %b",
                          r.kind, r.channel, r.value, r.no_valid_data, r.channel_total,
                          r.overflow, r.error_class, r.link_open);
      endfunction

      function void report(string what);
         mismatches++;
         if (mismatches <= 10) $display("mismatch: %s", what);
      endfunction

      function void check_result(logic [RSP_DATA_W-1:0] data);
         rsp_type got;
         rsp_type want;
         got = data[$bits(rsp_type)-1:0];
         if (awaited_results.size() == 0) begin
            report($sformatf("result with nothing awaited: %s", show(got)));
         end else begin
            want = awaited_results.pop_front();
            if (got.kind !== want.kind || got.channel !== want.channel ||
                got.value !== want.value || got.no_valid_data !== want.no_valid_data ||
                got.channel_total !== want.channel_total || got.overflow !== want.overflow ||
                got.error_class !== want.error_class || got.link_open !== want.link_open ||
                data[RSP_DATA_W-1:$bits(rsp_type)] !== '0)
               report($sformatf("expected %s / got %s pad %h", show(want), show(got),
                                data[RSP_DATA_W-1:$bits(rsp_type)]));
         end
      endfunction
   endclass

   logic                   clock;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_DATA_W-1:0]  req_tdata = '0;     // [7:0] rx_byte
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   // [2:0] kind, [7:3] channel, [23:8] value, [24] no_valid_data,
   // [30:25] channel_total, [31] overflow, [33:32] error_class, [34] link_open
   logic [RSP_DATA_W-1:0]  rsp_tdata;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_data = '0;

   parser_scoreboard sb;
   int  items_sent = 0;
   int  burst_left = 0;
   bit  steady_sender = 1'b0;
   int  idle_cycles = 0;
   int  ready_pct = 100;
   int  stretch_left = 0;

   ventilator_record_parser dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // receiver: ready odds change at random intervals, from never
   // stalling down to a trickle
   always @(posedge clock) begin
      if (stretch_left == 0) begin
         stretch_left = $urandom_range(50, 300);
         case ($urandom_range(0, 4))
            0: ready_pct = 100;
            1: ready_pct = 80;
            2: ready_pct = 50;
            3: ready_pct = 20;
            default: ready_pct = 5;
         endcase
      end else begin
         stretch_left--;
      end
      rsp_tready <= ($urandom_range(0, 99) < ready_pct);
   end

   // handshake monitor: results are checked before the byte taken at the
   // same edge is predicted, since that byte cannot have a result yet
   always @(posedge clock) begin
      if (reset) begin
         idle_cycles = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) sb.check_result(rsp_tdata);
         if (req_tvalid && req_tready) sb.note_rx_byte(req_tdata);
         if (csr_valid && csr_ready) sb.write_reg(csr_index, csr_data);
         if ((rsp_tvalid && rsp_tready) || (req_tvalid && req_tready) ||
             (csr_valid && csr_ready))
            idle_cycles = 0;
         else
            idle_cycles++;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("tb: failure");
            $finish;
         end
      end
   end

   // one link byte; bursts of random length with random gaps in between, no gaps for a steady sender
   task automatic send_byte(input logic [7:0] b, input bit counted);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 40);
         gap = steady_sender ? 0 : $urandom_range(0, 12);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tdata <= b;
      do @(posedge clock); while (!req_tready);
      if (counted) items_sent++;
   endtask

   task automatic send_word(input logic [15:0] w);
      send_byte(w[15:8], 1'b1);
      send_byte(w[7:0], 1'b1);
   endtask

   // end flag plus the byte the parser skips after it
   task automatic send_end();
      send_byte(sb.cfg.end_flag_code, 1'b1);
      send_byte(8'($urandom_range(0, 255)), 1'b0);
   endtask

   // random byte, leaning toward the edge values and the default flags
   function automatic logic [7:0] any_byte();
      case ($urandom_range(0, 11))
         0: return 8'h00;
         1: return 8'hFF;
         2: return 8'h7F;
         3: return 8'h80;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   function automatic logic [15:0] word_value();
      if ($urandom_range(0, 9) == 0) return NO_DATA_MARK;
      return {any_byte(), any_byte()};
   endfunction

   function automatic logic [7:0] error_byte(input bit allow_standby);
      logic [7:0] b;
      do begin
         case ($urandom_range(0, 3))
            0: b = sb.cfg.buffer_full_code;
            1: b = sb.cfg.escape_stop_code;
            2: b = sb.cfg.standby_code;
            default: b = any_byte();
         endcase
      end while (b == sb.cfg.end_flag_code || (!allow_standby && b == sb.cfg.standby_code));
      return b;
   endfunction

   // breath or settings record; mostly a few channels, some past the store
   // size and a few long enough to saturate the index
   task automatic channel_record(input logic [7:0] hdr);
      int r;
      int n;
      bit broken;
      logic [15:0] w;
      r = $urandom_range(0, 99);
      n = (r < 70) ? $urandom_range(1, 6) : (r < 90) ? $urandom_range(7, 36)
                                                   : $urandom_range(37, 70);
      broken = ($urandom_range(0, 99) < 8);
      send_byte(hdr, 1'b1);
      for (int i = 0; i < n; i++) begin
         w = word_value();
         // a high byte equal to the end flag would close the record early
         while (i > 0 && !broken && w[15:8] == sb.cfg.end_flag_code) w[15:8] = any_byte();
         send_word(w);
      end
      send_end();
   endtask

   // curve value or phase header, then run-mode traffic, then end flag
   task automatic curve_run();
      int n;
      int r;
      logic [7:0] b;
      if ($urandom_range(0, 1) == 1) begin
         send_byte(HDR_VALUE, 1'b1);
         send_word(word_value());
      end else begin
         send_byte(HDR_PHASE, 1'b1);
         send_byte(any_byte(), 1'b1);
      end
      n = $urandom_range(0, 8);
      repeat (n) begin
         r = $urandom_range(0, 9);
         if (r < 6) begin
            send_byte(sb.cfg.value_flag_code, 1'b1);
            send_word(word_value());
         end else if (r < 9) begin
            send_byte(sb.cfg.phase_flag_code, 1'b1);
            send_byte(any_byte(), 1'b1);
         end else begin
            // filler that run mode passes over
            do b = 8'($urandom_range(0, 255));
            while (b == sb.cfg.value_flag_code || b == sb.cfg.phase_flag_code ||
                   b == sb.cfg.end_flag_code);
            send_byte(b, 1'b0);
         end
      end
      send_end();
   endtask

   task automatic error_record(input bit allow_standby);
      int n;
      n = $urandom_range(1, 4);
      send_byte(HDR_ERROR, 1'b1);
      repeat (n) send_byte(error_byte(allow_standby), 1'b1);
      send_end();
   endtask

   // trend and alarm records are skipped up to the end flag
   task automatic skipped_record(input logic [7:0] hdr);
      int n;
      logic [7:0] b;
      n = $urandom_range(0, 6);
      send_byte(hdr, 1'b1);
      repeat (n) begin
         do b = any_byte(); while (b == sb.cfg.end_flag_code);
         send_byte(b, 1'b1);
      end
      send_end();
   endtask

   // stray bytes between records, kept off the error header so that a
   // standby code cannot close the link by accident
   task automatic line_noise();
      logic [7:0] b;
      repeat ($urandom_range(1, 3)) begin
         do b = any_byte(); while (b == HDR_ERROR);
         send_byte(b, 1'b0);
      end
   endtask

   task automatic random_record(input bit allow_standby);
      int r;
      r = $urandom_range(0, 99);
      if (r < 35) channel_record(HDR_BREATH);
      else if (r < 55) channel_record(HDR_SETTINGS);
      else if (r < 80) curve_run();
      else if (r < 90) error_record(allow_standby);
      else if (r < 93) skipped_record(HDR_TREND);
      else if (r < 96) skipped_record(HDR_ALARM);
      else line_noise();
   endtask

   // sender holds off until every awaited result has come and the parse
   // stage has had time to finish a byte that gives no result
   task automatic settle();
      req_tvalid <= 1'b0;
      burst_left = 0;
      @(negedge clock);
      while (sb.awaited_results.size() != 0) @(negedge clock);
      repeat (HOLD_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx, input logic [7:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= data;
      do @(posedge clock); while (!csr_ready);
   endtask

   task automatic load_settings(input logic [7:0] cc, input logic [7:0] end_code,
                                input logic [7:0] value_code, input logic [7:0] phase_code,
                                input logic [7:0] standby, input logic [7:0] buffer_full,
                                input logic [7:0] escape_stop);
      write_reg(CSR_CURVE_COUNT, cc);
      write_reg(CSR_END_FLAG, end_code);
      write_reg(CSR_VALUE_FLAG, value_code);
      write_reg(CSR_PHASE_FLAG, phase_code);
      write_reg(CSR_STANDBY, standby);
      write_reg(CSR_BUFFER_FULL, buffer_full);
      write_reg(CSR_ESCAPE_STOP, escape_stop);
      write_reg(CSR_UNMAPPED, 8'($urandom_range(0, 255)));
      csr_valid <= 1'b0;
   endtask

   // random settings; the end flag never equals a run-mode flag, otherwise
   // the parser could never leave run mode again
   task automatic load_random_settings();
      logic [7:0] cc;
      logic [7:0] end_code;
      logic [7:0] value_code;
      logic [7:0] phase_code;
      logic [7:0] buffer_full;
      logic [7:0] escape_stop;
      cc = 8'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 255) : $urandom_range(1, 4));
      end_code = 8'($urandom_range(0, 255));
      do value_code = 8'($urandom_range(0, 255)); while (value_code == end_code);
      if ($urandom_range(0, 3) == 0) phase_code = value_code;
      else do phase_code = 8'($urandom_range(0, 255)); while (phase_code == end_code);
      buffer_full = 8'($urandom_range(0, 255));
      escape_stop = ($urandom_range(0, 3) == 0) ? buffer_full : 8'($urandom_range(0, 255));
      load_settings(cc, end_code, value_code, phase_code, 8'($urandom_range(0, 255)),
                    buffer_full, escape_stop);
   endtask

   // settings per phase: edge codes, curve count zero and above range,
   // equal error codes (standby allowed from then on) and finally all three
   // run-mode flags equal, which traps the parser in run mode for good
   task automatic apply_phase_settings(input int phase);
      case (phase)
         1: load_settings(8'd4, 8'h00, 8'hFF, 8'hFE, 8'hFF, 8'h01, 8'h02);
         2: load_settings(8'd0, 8'hFF, 8'h00, 8'h00, 8'h55, 8'hAA, 8'hAA);
         3: load_settings(8'hFB, 8'h7F, 8'h80, 8'h81, 8'h00, 8'h01, 8'h02);
         7: load_settings(8'd2, 8'h7F, 8'h80, 8'h81, 8'h33, 8'h33, 8'h33);
         8: load_settings(8'd4, 8'h5A, 8'h5A, 8'h5A, 8'h00, 8'h01, 8'h02);
         default: load_random_settings();
      endcase
   endtask

   // short directed opening under the reset settings
   task automatic directed_bytes();
      // breath record: no-data marker on channel 0, then channel 1
      send_byte(HDR_BREATH, 1'b1);
      send_word(NO_DATA_MARK);
      send_word(16'hFF00);
      send_end();
      // one-channel settings record, the error header right after the end
      // flag must be skipped
      send_byte(HDR_SETTINGS, 1'b1);
      send_word(16'h0000);
      send_byte(sb.cfg.end_flag_code, 1'b1);
      send_byte(HDR_ERROR, 1'b0);
      // unknown header and a lone end flag are both ignored
      send_byte(8'h00, 1'b0);
      send_byte(sb.cfg.end_flag_code, 1'b0);
      // curve value, then a phase byte in run mode
      send_byte(HDR_VALUE, 1'b1);
      send_word(16'hFFFF);
      send_byte(sb.cfg.phase_flag_code, 1'b1);
      send_byte(8'h00, 1'b1);
      send_end();
      // error record with each non-standby class
      send_byte(HDR_ERROR, 1'b1);
      send_byte(sb.cfg.buffer_full_code, 1'b1);
      send_byte(sb.cfg.escape_stop_code, 1'b1);
      send_byte(8'hFF, 1'b1);
      send_end();
   endtask

   initial begin
      int phase_goal;
      sb = new();
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      directed_bytes();
      for (int p = 0; p < PHASE_COUNT; p++) begin
         if (p > 0) begin
            settle();
            apply_phase_settings(p);
         end
         steady_sender = (p % 3 == 1);
         phase_goal = items_sent + ITEMS_PER_PHASE;
         while (items_sent < phase_goal) random_record(p >= 7);
      end
      settle();
      if (sb.mismatches == 0 && sb.awaited_results.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

### sim.f
design/vrp_pkg.sv
design/vrp_csr.sv
design/vrp_parse.sv
design/ventilator_record_parser.sv
verif/testbench.sv
